FILE: design/cbv_pkg.sv
// ----------------------------------------------------------------------------
// cbv_pkg: shared types and constants for the clockwise bearing block
// Payload structs, the CORDIC stage record and the arctangent table.
// ----------------------------------------------------------------------------
package cbv_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int ANGLE_WIDTH      = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 32;

    // coordinates enter the datapath scaled by 2^(60 - COORD_WIDTH)
    localparam int SCALE_SHIFT = 60 - COORD_WIDTH;
    // worst-case CORDIC growth stays below 2^61, plus the sign
    localparam int XW          = 63;

    localparam int PADDR_WIDTH = 3;

    // register index, taken from paddr[2]
    localparam logic REG_SCREEN_MODE = 1'b0;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] dx;
        logic signed [COORD_WIDTH-1:0] dy;
    } request_t;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] bearing;
        logic                   zero_vector;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          z;
    } stage_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h2000_0000;
            5'd1:    a = 32'h12E4_051E;
            5'd2:    a = 32'h09FB_385B;
            5'd3:    a = 32'h0511_11D4;
            5'd4:    a = 32'h028B_0D43;
            5'd5:    a = 32'h0145_D7E1;
            5'd6:    a = 32'h00A2_F61E;
            5'd7:    a = 32'h0051_7C55;
            5'd8:    a = 32'h0028_BE53;
            5'd9:    a = 32'h0014_5F2F;
            5'd10:   a = 32'h000A_2F98;
            5'd11:   a = 32'h0005_17CC;
            5'd12:   a = 32'h0002_8BE6;
            5'd13:   a = 32'h0001_45F3;
            5'd14:   a = 32'h0000_A2FA;
            5'd15:   a = 32'h0000_517D;
            5'd16:   a = 32'h0000_28BE;
            5'd17:   a = 32'h0000_145F;
            5'd18:   a = 32'h0000_0A30;
            5'd19:   a = 32'h0000_0518;
            5'd20:   a = 32'h0000_028C;
            5'd21:   a = 32'h0000_0146;
            5'd22:   a = 32'h0000_00A3;
            5'd23:   a = 32'h0000_0051;
            5'd24:   a = 32'h0000_0029;
            5'd25:   a = 32'h0000_0014;
            5'd26:   a = 32'h0000_000A;
            5'd27:   a = 32'h0000_0005;
            5'd28:   a = 32'h0000_0003;
            5'd29:   a = 32'h0000_0001;
            5'd30:   a = 32'h0000_0001;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

FILE: design/cbv_entry.sv
// ----------------------------------------------------------------------------
// cbv_entry: axis mapping and quadrant pre-rotation
// Maps (dx, dy) to up/right components, scales them and folds the lower
// half-plane onto the upper one with a half-turn offset on the angle.
// ----------------------------------------------------------------------------
module cbv_entry
    import cbv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    input  logic     screen_mode,
    output stage_t   stage_out
);

    logic signed [COORD_WIDTH:0] dx_ext;
    logic signed [COORD_WIDTH:0] dy_ext;
    logic signed [COORD_WIDTH:0] up;
    logic signed [XW-1:0]        x_scaled;
    logic signed [XW-1:0]        y_scaled;
    stage_t                      stage_reg;
    stage_t                      stage_next;

    always_comb
    begin
        dx_ext   = {request.dx[COORD_WIDTH-1], request.dx};
        dy_ext   = {request.dy[COORD_WIDTH-1], request.dy};
        up       = screen_mode ? -dy_ext : dy_ext;
        x_scaled = XW'(up) <<< SCALE_SHIFT;
        y_scaled = XW'(dx_ext) <<< SCALE_SHIFT;

        stage_next.valid = start;
        stage_next.zero  = (request.dx == '0) && (request.dy == '0);
        // vector points down: rotate by a half turn
        if (up[COORD_WIDTH])
        begin
            stage_next.x = -x_scaled;
            stage_next.y = -y_scaled;
            stage_next.z = 32'h8000_0000;
        end
        else
        begin
            stage_next.x = x_scaled;
            stage_next.y = y_scaled;
            stage_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: design/cbv_cell.sv
// ----------------------------------------------------------------------------
// cbv_cell: one CORDIC vectoring step
// Rotates the vector toward the up axis by atan(2^-STEP) and accumulates
// the angle, then hands the record to the next cell.
// ----------------------------------------------------------------------------
module cbv_cell
    import cbv_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  stage_t stage_in,
    output stage_t stage_out
);

    logic signed [XW-1:0] x_cur;
    logic signed [XW-1:0] y_cur;
    logic signed [XW-1:0] x_shift;
    logic signed [XW-1:0] y_shift;
    logic [31:0]          angle;
    stage_t               stage_reg;
    stage_t               stage_next;

    always_comb
    begin
        x_cur   = stage_in.x;
        y_cur   = stage_in.y;
        // arithmetic shift floors toward minus infinity
        x_shift = x_cur >>> STEP;
        y_shift = y_cur >>> STEP;
        angle   = atan_turn(5'(STEP));

        stage_next.valid = stage_in.valid;
        stage_next.zero  = stage_in.zero;
        if (!y_cur[XW-1])
        begin
            stage_next.x = x_cur + y_shift;
            stage_next.y = y_cur - x_shift;
            stage_next.z = stage_in.z + angle;
        end
        else
        begin
            stage_next.x = x_cur - y_shift;
            stage_next.y = y_cur + x_shift;
            stage_next.z = stage_in.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: design/cbv_round.sv
// ----------------------------------------------------------------------------
// cbv_round: output rounding and result register
// Rounds the turn accumulator to the bearing width, half up, wrapping a
// full turn to zero, and forces zero for the zero vector.
// ----------------------------------------------------------------------------
module cbv_round
    import cbv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  stage_t  stage_in,
    output logic    done,
    output result_t result
);

    logic [31:0] z_round;
    logic        done_reg;
    result_t     result_reg;
    result_t     result_next;

    generate
        if (ANGLE_WIDTH < 32)
        begin : g_round
            assign z_round = stage_in.z + (32'd1 << (31 - ANGLE_WIDTH));
        end
        else
        begin : g_exact
            assign z_round = stage_in.z;
        end
    endgenerate

    always_comb
    begin
        result_next.zero_vector = stage_in.zero;
        result_next.bearing     = stage_in.zero ? '0 : z_round[31 -: ANGLE_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/clockwise_bearing_from_vector.sv
// ----------------------------------------------------------------------------
// clockwise_bearing_from_vector: bearing of a vector, clockwise from up
// Pipelined CORDIC vectoring: one entry stage, a chain of step cells and a
// rounding stage; an APB-style port holds the axis mode.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request (dx, dy) with start high for one cycle per vector. busy
//   stays low, so a new request may enter on every clock edge.
//   Each result appears on result for one cycle with done high, once its
//   request has passed the entry register (axis mapping and pre-rotation),
//   one register per cell of the CORDIC chain and the rounding register.
//   Throughput is one vector per cycle, set by the chain of cells, each of
//   which passes its vector on at every edge.
//   bearing counts 2^16 per full turn, 0 = up. The zero vector gives
//   bearing 0 with zero_vector set.
//   The receiver cannot stall: results must be taken when done is high.
//   screen_mode (address 0) selects y-down axes; change it only while no
//   request is in flight. Reset clears screen_mode and empties the chain,
//   dropping any request in flight.
// ----------------------------------------------------------------------------
module clockwise_bearing_from_vector
    import cbv_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  request_t               request,
    output logic                   done,
    output result_t                result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int LATENCY = CORDIC_STEPS + 2;

    logic   screen_mode_reg;
    logic   screen_mode_next;
    logic   reg_write;
    stage_t chain [CORDIC_STEPS+1];

    assign busy   = 1'b0;
    assign pready = 1'b1;

    always_comb
    begin
        reg_write        = psel && penable && pwrite && (paddr[2] == REG_SCREEN_MODE);
        screen_mode_next = reg_write ? pwdata[0] : screen_mode_reg;
        prdata           = (paddr[2] == REG_SCREEN_MODE) ? {31'b0, screen_mode_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_mode_reg <= 1'b0;
        end
        else
        begin
            screen_mode_reg <= screen_mode_next;
        end
    end

    cbv_entry u_entry (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .screen_mode (screen_mode_reg),
        .stage_out   (chain[0])
    );

    generate
        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_cell
            cbv_cell #(
                .STEP (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .stage_in  (chain[i]),
                .stage_out (chain[i+1])
            );
        end
    endgenerate

    cbv_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage_in (chain[CORDIC_STEPS]),
        .done     (done),
        .result   (result)
    );

    // every request comes out as a done pulse once it has passed the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("request did not produce a result after the pipeline latency");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching request");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (start && request.dx == '0 && request.dy == '0)
            |-> ##LATENCY (result.zero_vector && result.bearing == '0))
        else $error("zero vector not flagged or bearing not forced to zero");

endmodule
